// ----- src/lbtg_pkg.sv -----
package lbtg_pkg;

  // Gate modes; the unused code is handled as idle by the default arms.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LISTEN = 2'd1,
    MODE_QUIET  = 2'd2
  } gate_mode_t;

  // Item operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result status codes.
  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_BUSY  = 1'b1;

  // Register indexes on the configuration port.
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LISTEN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_FREE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RSSI_THRESH  = 2'd2;

  localparam int unsigned ADDR_W = 4;

  // Counter limits.
  localparam logic [24:0] LISTEN_MAX = 25'h1FF_FFFF;
  localparam logic [23:0] QUIET_MAX  = 24'hFF_FFFF;

  // Reset value of the RSSI threshold in dBm.
  localparam logic signed [8:0] RSSI_THRESH_RST = -9'sd90;

  typedef struct packed {
    logic [23:0]        max_listen_time;
    logic [23:0]        channel_free_time;
    logic signed [8:0]  rssi_threshold;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [7:0]         payload_length;
    logic signed [8:0]  rssi_sample;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         granted_length;
  } result_t;

endpackage

// ----- src/lbtg_cfg_regs.sv -----
module lbtg_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lbtg_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output lbtg_pkg::cfg_t              cfg
);

  lbtg_pkg::cfg_t cfg_r;
  logic [lbtg_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx    = cfg_paddr[lbtg_pkg::ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_listen_time   <= 24'd0;
      cfg_r.channel_free_time <= 24'd0;
      cfg_r.rssi_threshold    <= lbtg_pkg::RSSI_THRESH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lbtg_pkg::REG_MAX_LISTEN:   cfg_r.max_listen_time   <= cfg_pwdata[23:0];
        lbtg_pkg::REG_CHANNEL_FREE: cfg_r.channel_free_time <= cfg_pwdata[23:0];
        lbtg_pkg::REG_RSSI_THRESH:  cfg_r.rssi_threshold    <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      lbtg_pkg::REG_MAX_LISTEN:   cfg_prdata = {8'd0, cfg_r.max_listen_time};
      lbtg_pkg::REG_CHANNEL_FREE: cfg_prdata = {8'd0, cfg_r.channel_free_time};
      lbtg_pkg::REG_RSSI_THRESH:  cfg_prdata = {{23{cfg_r.rssi_threshold[8]}},
                                                cfg_r.rssi_threshold};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/lbtg_gate_core.sv -----
module lbtg_gate_core (
  input  logic              clk,
  input  logic              rst_n,
  input  lbtg_pkg::cfg_t    cfg,
  input  lbtg_pkg::item_t   item,
  input  logic              take,
  output logic              res_valid,
  output lbtg_pkg::result_t res
);

  lbtg_pkg::gate_mode_t mode_r, mode_nxt;
  logic [24:0] listen_elapsed_r, listen_elapsed_nxt;
  logic [23:0] quiet_elapsed_r, quiet_elapsed_nxt;
  logic [7:0]  pending_length_r, pending_length_nxt;
  logic        busy;
  logic [24:0] listen_inc;
  logic [23:0] quiet_inc;

  // A sample strictly above the threshold means the channel is busy.
  assign busy = item.rssi_sample > cfg.rssi_threshold;

  // Saturating counter increments.
  assign listen_inc = (listen_elapsed_r == lbtg_pkg::LISTEN_MAX) ?
                      listen_elapsed_r : listen_elapsed_r + 25'd1;
  assign quiet_inc  = (quiet_elapsed_r == lbtg_pkg::QUIET_MAX) ?
                      quiet_elapsed_r : quiet_elapsed_r + 24'd1;

  // Next state and result for the item at the input register.
  always_comb begin
    mode_nxt           = mode_r;
    listen_elapsed_nxt = listen_elapsed_r;
    quiet_elapsed_nxt  = quiet_elapsed_r;
    pending_length_nxt = pending_length_r;
    res_valid          = 1'b0;
    res.status         = lbtg_pkg::STATUS_GRANT;
    res.granted_length = pending_length_r;
    if (item.op == lbtg_pkg::OP_START) begin
      // A start drops any open request and begins from scratch.
      pending_length_nxt = item.payload_length;
      listen_elapsed_nxt = 25'd0;
      quiet_elapsed_nxt  = 24'd0;
      res.granted_length = item.payload_length;
      if (cfg.max_listen_time == 24'd0) begin
        res_valid = 1'b1;
        mode_nxt  = lbtg_pkg::MODE_IDLE;
      end else begin
        mode_nxt  = lbtg_pkg::MODE_LISTEN;
      end
    end else begin
      case (mode_r)
        lbtg_pkg::MODE_LISTEN: begin
          if (listen_elapsed_r > {1'b0, cfg.max_listen_time}) begin
            res_valid  = 1'b1;
            res.status = lbtg_pkg::STATUS_BUSY;
            mode_nxt   = lbtg_pkg::MODE_IDLE;
          end else begin
            if (!busy) begin
              mode_nxt          = lbtg_pkg::MODE_QUIET;
              quiet_elapsed_nxt = 24'd0;
            end
            listen_elapsed_nxt = listen_inc;
          end
        end
        lbtg_pkg::MODE_QUIET: begin
          if (busy) begin
            mode_nxt           = lbtg_pkg::MODE_LISTEN;
            listen_elapsed_nxt = listen_inc;
          end else if (quiet_elapsed_r >= cfg.channel_free_time) begin
            res_valid = 1'b1;
            mode_nxt  = lbtg_pkg::MODE_IDLE;
          end else begin
            quiet_elapsed_nxt  = quiet_inc;
            listen_elapsed_nxt = listen_inc;
          end
        end
        default: begin
          // Ticks while idle are ignored.
          mode_nxt = lbtg_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  // State registers advance only when the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= lbtg_pkg::MODE_IDLE;
      listen_elapsed_r <= 25'd0;
      quiet_elapsed_r  <= 24'd0;
      pending_length_r <= 8'd0;
    end else if (take) begin
      mode_r           <= mode_nxt;
      listen_elapsed_r <= listen_elapsed_nxt;
      quiet_elapsed_r  <= quiet_elapsed_nxt;
      pending_length_r <= pending_length_nxt;
    end
  end

`ifndef SYNTHESIS
  // Every result closes the request.
  a_result_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_valid) |=> (mode_r == lbtg_pkg::MODE_IDLE))
    else $error("gate not idle after a result");

  // A start with a listen budget opens listening.
  a_start_listens: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.op == lbtg_pkg::OP_START && cfg.max_listen_time != 24'd0)
    |=> (mode_r == lbtg_pkg::MODE_LISTEN && listen_elapsed_r == 25'd0))
    else $error("start did not open listening");

  // Quiet is only reached after at least one counted listen tick.
  a_quiet_has_listened: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == lbtg_pkg::MODE_QUIET) |-> (listen_elapsed_r != 25'd0))
    else $error("quiet with zero listen time");

  // Without a take the state holds.
  a_hold_without_take: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> ($stable(mode_r) && $stable(listen_elapsed_r)
               && $stable(pending_length_r)))
    else $error("gate state moved without an item");
`endif

endmodule

// ----- src/listen_before_talk_gate_unit.sv -----
// The gate state update is compare and saturating increment logic between the
// input register and the result register; a taken item's result is registered.
// Throughput: one item per cycle unless a stalled result blocks the take, though
// a waiting result does not block intake while the item produces no result.
// Reset (rst_n, synchronous, active low) empties both registers, sets the gate
// idle with cleared counters and loads the register reset values.
module listen_before_talk_gate_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [7:0]                  in_payload_length,
  input  logic signed [8:0]           in_rssi_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [7:0]                  out_granted_length,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lbtg_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  lbtg_pkg::cfg_t    cfg;
  lbtg_pkg::item_t   in_item_r;
  lbtg_pkg::result_t res, out_res_r;
  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic res_valid;
  logic take;
  logic accept;

  lbtg_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lbtg_gate_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (in_item_r),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held item is taken unless its result would overwrite a stalled one.
  assign take     = in_valid_r && (!out_valid_r || !out_stall || !res_valid);
  assign in_stall = in_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  assign in_valid_nxt  = accept ? 1'b1 : (take ? 1'b0 : in_valid_r);
  assign out_valid_nxt = (take && res_valid) ? 1'b1 :
                         (!out_stall ? 1'b0 : out_valid_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.op             <= in_op;
      in_item_r.payload_length <= in_payload_length;
      in_item_r.rssi_sample    <= in_rssi_sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_granted_length = out_res_r.granted_length;

endmodule
